### rtl/core/m1u_pkg.sv
// Shared types, constants and word builders for the MIDI 1.0 to UMP converter.
`default_nettype none

package m1u_pkg;

  // status bytes
  localparam logic [7:0] ST_NONE        = 8'h00;
  localparam logic [7:0] ST_SYSEX_START = 8'hF0;
  localparam logic [7:0] ST_COMMON_LO   = 8'hF1;
  localparam logic [7:0] ST_COMMON_HI   = 8'hF6;
  localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
  localparam logic [7:0] ST_REALTIME    = 8'hF8;

  // SysEx bytes carried by one type 3 packet
  localparam int unsigned SX_DEPTH    = 6;
  localparam logic [2:0]  SX_FULL_CNT = 3'(SX_DEPTH);
  localparam logic [2:0]  SX_LAST_IDX = 3'(SX_DEPTH - 1);

  localparam logic [1:0] WC_ONE = 2'd1;
  localparam logic [1:0] WC_TWO = 2'd2;

  typedef enum logic [3:0] {
    UMP_SYSTEM = 4'd1,
    UMP_CV1    = 4'd2,
    UMP_SYSEX7 = 4'd3
  } ump_type_e;

  typedef enum logic [3:0] {
    SX_COMPLETE = 4'd0,
    SX_START    = 4'd1,
    SX_CONTINUE = 4'd2,
    SX_END      = 4'd3
  } sx_kind_e;

  typedef logic [SX_DEPTH-1:0][6:0] sx_bytes_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] word_first;
    logic [31:0] word_second;
    logic [1:0]  word_count;
  } m1u_result_t;

  // number of data bytes that follow a status byte
  function automatic logic [1:0] data_len(input logic [7:0] st);
    logic [1:0] len;
    case (st[7:4])
      4'h8, 4'h9, 4'hA, 4'hB, 4'hE: len = 2'd2;
      4'hC, 4'hD:                   len = 2'd1;
      default: begin
        if (st inside {8'hF1, 8'hF3}) begin
          len = 2'd1;
        end else if (st == 8'hF2) begin
          len = 2'd2;
        end else begin
          len = 2'd0;
        end
      end
    endcase
    return len;
  endfunction

  function automatic m1u_result_t one_word(input ump_type_e typ, input logic [3:0] grp,
                                           input logic [7:0] st, input logic [6:0] d0,
                                           input logic [6:0] d1);
    m1u_result_t r;
    r.valid       = 1'b1;
    r.word_first  = {typ, grp, st, 1'b0, d0, 1'b0, d1};
    r.word_second = '0;
    r.word_count  = WC_ONE;
    return r;
  endfunction

  // bytes at or beyond the count read as zero
  function automatic m1u_result_t sysex_words(input logic [3:0] grp, input sx_kind_e kind,
                                              input logic [2:0] cnt, input sx_bytes_t bytes);
    m1u_result_t r;
    sx_bytes_t   b;
    for (int i = 0; i < SX_DEPTH; i++) begin
      b[i] = (3'(i) < cnt) ? bytes[i] : 7'd0;
    end
    r.valid       = 1'b1;
    r.word_first  = {UMP_SYSEX7, grp, kind, 1'b0, cnt, 1'b0, b[0], 1'b0, b[1]};
    r.word_second = {1'b0, b[2], 1'b0, b[3], 1'b0, b[4], 1'b0, b[5]};
    r.word_count  = WC_TWO;
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/m1u_xlate.sv
// Translation state and per-byte decode: running status, data gathering, SysEx packing.
`default_nettype none

module m1u_xlate (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic [7:0]          byte_i,
  input  wire logic [3:0]          group_i,
  output m1u_pkg::m1u_result_t     res_o
);
  import m1u_pkg::*;

  logic       in_sysex_q, in_sysex_d;
  logic       opened_q, opened_d;
  logic [2:0] fill_q, fill_d;
  logic [7:0] status_q, status_d;
  logic [1:0] needed_q, needed_d;
  logic [1:0] idx_q, idx_d;
  logic [6:0] db0_q, db0_d;
  logic [6:0] db1_q, db1_d;

  sx_bytes_t  sx_q;
  sx_bytes_t  sx_next;
  logic       sx_wr;

  logic [6:0] d0, d1, d1_sys;
  logic [1:0] idx_inc;

  always_comb begin
    sx_next         = sx_q;
    sx_next[fill_q] = byte_i[6:0];
    // merge the incoming data byte into the pair before building a word
    d0      = idx_q[0] ? db0_q : byte_i[6:0];
    d1      = idx_q[0] ? byte_i[6:0] : db1_q;
    d1_sys  = (needed_q >= 2'd2) ? d1 : 7'd0;
    idx_inc = idx_q + 2'd1;
  end

  always_comb begin
    in_sysex_d = in_sysex_q;
    opened_d   = opened_q;
    fill_d     = fill_q;
    status_d   = status_q;
    needed_d   = needed_q;
    idx_d      = idx_q;
    db0_d      = db0_q;
    db1_d      = db1_q;
    sx_wr      = 1'b0;
    res_o      = '0;
    if (en_i) begin
      if (byte_i >= ST_REALTIME) begin
        // real-time passes through without touching state
        res_o = one_word(UMP_SYSTEM, group_i, byte_i, 7'd0, 7'd0);
      end else if (byte_i == ST_SYSEX_START) begin
        in_sysex_d = 1'b1;
        opened_d   = 1'b0;
        fill_d     = '0;
        status_d   = ST_NONE;
      end else if (byte_i == ST_SYSEX_END) begin
        if (in_sysex_q) begin
          res_o      = sysex_words(group_i, opened_q ? SX_END : SX_COMPLETE, fill_q, sx_q);
          in_sysex_d = 1'b0;
          opened_d   = 1'b0;
          fill_d     = '0;
        end
      end else if (in_sysex_q && !byte_i[7]) begin
        sx_wr = 1'b1;
        if (fill_q == SX_LAST_IDX) begin
          res_o    = sysex_words(group_i, opened_q ? SX_CONTINUE : SX_START,
                                 SX_FULL_CNT, sx_next);
          opened_d = 1'b1;
          fill_d   = '0;
        end else begin
          fill_d = fill_q + 3'd1;
        end
      end else begin
        // a status byte inside SysEx drops the partial buffer silently
        if (in_sysex_q) begin
          in_sysex_d = 1'b0;
          opened_d   = 1'b0;
          fill_d     = '0;
        end
        if (byte_i[7]) begin
          status_d = byte_i;
          needed_d = data_len(byte_i);
          idx_d    = '0;
          if (byte_i >= ST_COMMON_LO && byte_i <= ST_COMMON_HI) begin
            if (data_len(byte_i) == 2'd0) begin
              status_d = ST_NONE;
              res_o    = one_word(UMP_SYSTEM, group_i, byte_i, 7'd0, 7'd0);
            end
          end else begin
            db0_d = '0;
            db1_d = '0;
          end
        end else if (status_q != ST_NONE) begin
          if (idx_inc < needed_q) begin
            idx_d = idx_inc;
            if (idx_q[0]) begin
              db1_d = byte_i[6:0];
            end else begin
              db0_d = byte_i[6:0];
            end
          end else begin
            if (status_q >= ST_COMMON_LO) begin
              res_o = one_word(UMP_SYSTEM, group_i, status_q, d0, d1_sys);
            end else begin
              res_o = one_word(UMP_CV1, group_i, status_q, d0, d1);
            end
            idx_d = '0;
            db0_d = '0;
            db1_d = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sysex_q <= 1'b0;
      opened_q   <= 1'b0;
      fill_q     <= '0;
      status_q   <= ST_NONE;
      needed_q   <= '0;
      idx_q      <= '0;
      db0_q      <= '0;
      db1_q      <= '0;
    end else begin
      in_sysex_q <= in_sysex_d;
      opened_q   <= opened_d;
      fill_q     <= fill_d;
      status_q   <= status_d;
      needed_q   <= needed_d;
      idx_q      <= idx_d;
      db0_q      <= db0_d;
      db1_q      <= db1_d;
    end
  end

  // SysEx byte store, only entries below the fill count are ever read
  always_ff @(posedge clk_i) begin
    if (sx_wr) begin
      sx_q[fill_q] <= byte_i[6:0];
    end
  end

endmodule

`default_nettype wire

### rtl/core/m1u_out_stage.sv
// Result register holding one UMP packet until the downstream transfer.
`default_nettype none

module m1u_out_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire m1u_pkg::m1u_result_t res_i,
  input  wire logic                out_stall_i,
  output logic                     out_valid_o,
  output logic [31:0]              word_first_o,
  output logic [31:0]              word_second_o,
  output logic [1:0]               word_count_o
);
  import m1u_pkg::*;

  logic        valid_q, valid_d;
  logic [31:0] first_q, second_q;
  logic [1:0]  count_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      // load only happens when the register is empty or draining this cycle
      valid_d = res_i.valid;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_i.valid) begin
      first_q  <= res_i.word_first;
      second_q <= res_i.word_second;
      count_q  <= res_i.word_count;
    end
  end

  assign out_valid_o   = valid_q;
  assign word_first_o  = first_q;
  assign word_second_o = second_q;
  assign word_count_o  = count_q;

endmodule

`default_nettype wire

### rtl/core/midi1_byte_to_ump_converter_unit.sv
// Top level of the MIDI 1.0 byte stream to UMP converter.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o   midi_byte_i[7:0]
//   out      output     out_valid_o/out_stall_i word_first_o, word_second_o, word_count_o
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_group_i[3:0]
//
// One byte per cycle sustained while out_stall_i is low; each byte goes into the input
// register, then is decoded into the result register as its packet.
// Bytes that complete no packet still pass through decode and produce nothing.
// Output stall holds the result register; the input register keeps taking a byte as long
// as the pending one can move on, so in_stall_o rises only when both stages are full.
// Reset clears all control and translation state; group resets to 0. cfg is always ready.
`default_nettype none

module midi1_byte_to_ump_converter_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  midi_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      word_first_o,
  output logic [31:0]      word_second_o,
  output logic [1:0]       word_count_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_group_i
);
  import m1u_pkg::*;

  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  logic [3:0]  group_q;
  logic        advance;
  logic        in_xfer;
  m1u_result_t res;

  assign advance     = in_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      group_q    <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        group_q <= cfg_group_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= midi_byte_i;
    end
  end

  m1u_xlate u_xlate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .byte_i  (in_byte_q),
    .group_i (group_q),
    .res_o   (res)
  );

  m1u_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (advance),
    .res_i         (res),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .word_first_o  (word_first_o),
    .word_second_o (word_second_o),
    .word_count_o  (word_count_o)
  );

  // input side only backs up when the result register is full and stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // two-word packets are exactly the SysEx ones
  a_count_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((word_count_o == WC_TWO) == (word_first_o[31:28] == UMP_SYSEX7)))
    else $error("word count does not match packet type");

  // one-word packets carry a zero second word
  a_second_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && word_count_o == WC_ONE) |-> (word_second_o == 32'd0))
    else $error("second word not zero on one-word packet");

  // a packet that was stalled is still there on the next edge
  a_hold_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled packet lost");

endmodule

`default_nettype wire
